// ===== hw/rtl/utbd_pkg.sv =====
// Shared types, constants and helpers of the radix digit converter.
package utbd_pkg;

   localparam int          INPUT_VALUE_BITS = 64;
   localparam int          RADIX_BITS       = 6;
   localparam int          CHAR_BITS        = 7;
   localparam int          STEP_BITS        = 8;   // dividend bits retired per divide cycle
   localparam logic [5:0]  RADIX_MIN        = 6'd2;
   localparam logic [5:0]  RADIX_MAX        = 6'd36;
   localparam logic [6:0]  DECIMAL_DIGITS   = 7'd10;
   localparam logic [6:0]  CHAR_ZERO        = 7'd48;  // '0'
   localparam logic [6:0]  CHAR_UPPER_A     = 7'd65;  // 'A'

   typedef struct packed {
      logic [INPUT_VALUE_BITS-1:0] value;
      logic [RADIX_BITS-1:0]       radix;
   } req_payload_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] digit_char;
      logic                 is_last;
   } rsp_payload_type;

   typedef struct packed {
      logic load;      // capture a new request
      logic div_step;  // retire one chunk of the dividend
      logic store;     // write one digit, start the next division
      logic emit;      // read one digit back toward the result port
   } ctl_cmd_type;

   typedef struct packed {
      logic chunk_last;  // final chunk of the current division
      logic quot_zero;   // quotient left after the last division is zero
      logic ptr_zero;    // read pointer is at the least significant digit
   } dp_status_type;

   function automatic logic [CHAR_BITS-1:0] digit_ascii(input logic [RADIX_BITS-1:0] digit);
      logic [CHAR_BITS-1:0] d;
      d = {1'b0, digit};
      if (d < DECIMAL_DIGITS) begin
         return CHAR_ZERO + d;
      end
      return CHAR_UPPER_A + (d - DECIMAL_DIGITS);
   endfunction

endpackage

// ===== hw/rtl/utbd_controller.sv =====
// Sequencing state machine of the radix digit converter.
module utbd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  utbd_pkg::dp_status_type status,
   output utbd_pkg::ctl_cmd_type   cmd
);
   import utbd_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_STORE  = 2'd2;
   localparam logic [1:0] ST_EMIT   = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.chunk_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = status.quot_zero ? ST_EMIT : ST_DIVIDE;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.ptr_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/utbd_datapath.sv =====
// Divider, digit store and result register of the radix digit converter.
module utbd_datapath #(
   parameter int VALUE_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  utbd_pkg::req_payload_type req_payload,
   input  utbd_pkg::ctl_cmd_type     cmd,
   output utbd_pkg::dp_status_type   status,
   output logic                      rsp_strobe,
   output utbd_pkg::rsp_payload_type rsp_payload
);
   import utbd_pkg::*;

   localparam int CHUNKS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS = CHUNKS * STEP_BITS;
   localparam int CHUNK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int IDX_W    = $clog2(VALUE_BITS);
   localparam int CNT_W    = $clog2(VALUE_BITS + 1);

   logic [PAD_BITS-1:0]   quot_ff, quot_in;
   logic [RADIX_BITS-1:0] radix_ff, radix_in;
   logic [RADIX_BITS-1:0] rem_ff, rem_in;
   logic [CHUNK_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic [CHAR_BITS-1:0]  mem_ff [VALUE_BITS];
   logic [CHAR_BITS-1:0]  rd_data_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_last_ff;

   logic [RADIX_BITS:0]   rem_work;
   logic [STEP_BITS-1:0]  chunk;
   logic [STEP_BITS-1:0]  qbits;
   logic [RADIX_BITS-1:0] rem_div;

   // Restoring long division of one chunk against the narrow radix.
   always_comb begin
      rem_work = {1'b0, rem_ff};
      chunk    = quot_ff[PAD_BITS-1 -: STEP_BITS];
      qbits    = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         rem_work = {rem_work[RADIX_BITS-1:0], chunk[i]};
         if (rem_work >= {1'b0, radix_ff}) begin
            rem_work = rem_work - {1'b0, radix_ff};
            qbits[i] = 1'b1;
         end
      end
      rem_div = rem_work[RADIX_BITS-1:0];
   end

   always_comb begin
      quot_in  = quot_ff;
      radix_in = radix_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.load) begin
         quot_in = PAD_BITS'(req_payload.value[VALUE_BITS-1:0]);
         if (req_payload.radix < RADIX_MIN) begin
            radix_in = RADIX_MIN;
         end else if (req_payload.radix > RADIX_MAX) begin
            radix_in = RADIX_MAX;
         end else begin
            radix_in = req_payload.radix;
         end
         rem_in   = '0;
         step_in  = '0;
         count_in = '0;
      end
      if (cmd.div_step) begin
         quot_in = (quot_ff << STEP_BITS) | PAD_BITS'(qbits);
         rem_in  = rem_div;
         step_in = step_ff + 1'b1;
      end
      if (cmd.store) begin
         rem_in   = '0;
         step_in  = '0;
         count_in = count_ff + 1'b1;
         ptr_in   = count_ff[IDX_W-1:0];
      end
      if (cmd.emit) begin
         ptr_in = ptr_ff - 1'b1;
      end
   end

   assign status.chunk_last = (step_ff == CHUNK_W'(CHUNKS - 1));
   assign status.quot_zero  = (quot_ff == '0);
   assign status.ptr_zero   = (ptr_ff == '0);

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      radix_ff <= radix_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      count_ff <= count_in;
      ptr_ff   <= ptr_in;
   end

   // Digit store, least significant digit at the lowest address.
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem_ff[count_ff[IDX_W-1:0]] <= digit_ascii(rem_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rd_data_ff  <= mem_ff[ptr_ff];
         rsp_last_ff <= status.ptr_zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp_strobe             = rsp_valid_ff;
   assign rsp_payload.digit_char = rd_data_ff;
   assign rsp_payload.is_last    = rsp_last_ff;

   a_digits_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |=> rsp_valid_ff)
      else $error("digit stream broke before the last digit");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |=> !rsp_valid_ff)
      else $error("result strobe right after the last digit");

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (count_ff < CNT_W'(VALUE_BITS)))
      else $error("digit count overran the digit store");

   a_radix_clamped: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (radix_ff >= RADIX_MIN && radix_ff <= RADIX_MAX))
      else $error("divisor outside the clamped radix range");

endmodule

// ===== hw/rtl/unsigned_to_base_digits_unit.sv =====
// Top level of the unsigned integer to ASCII radix digit converter.
// Sequence: a load from idle, then for each digit the divide steps and a store; after the
//   last store the first digit leaves through the EMIT state and the result register; later digits follow each cycle.
// Requests: one at a time, busy until the digits are read out; at most VALUE_BITS digits
//   (binary), each digit divided out by the 8-bit-per-cycle divider loop.
// Reset: synchronous, active high; clears the state machine and the result strobe.
// The receiver cannot stall: each digit is on rsp_payload for one cycle with rsp_strobe.
module unsigned_to_base_digits_unit #(
   parameter int VALUE_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  utbd_pkg::req_payload_type req_payload,
   output logic                      rsp_strobe,
   output utbd_pkg::rsp_payload_type rsp_payload
);
   import utbd_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // Sequence: load the request, divide by the radix one chunk a cycle,
   // store each remainder as an ASCII digit, repeat until the quotient is
   // zero, then read the digits back most significant first.
   utbd_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Hold the working quotient, the digit store and the result register.
   utbd_datapath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the radix digit converter: random and directed requests, digit checks.
module testbench;
   import utbd_pkg::*;

   localparam int          DUT_VALUE_BITS = 64;
   localparam int          MAX_DIGITS     = 64;
   localparam logic [63:0] VALUE_MASK     = (DUT_VALUE_BITS >= 64) ? {64{1'b1}}
                                            : ((64'd1 << DUT_VALUE_BITS) - 64'd1);
   localparam int          RANDOM_PER_PHASE = 113;
   localparam int          DRAIN_CYCLES     = 100;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   req_payload_type req_payload = '0;
   logic            rsp_strobe;
   rsp_payload_type rsp_payload;

   // Requests waiting to be issued; the head is what the driver presents.
   req_payload_type pending_requests[$];
   // Digits the converter still owes, oldest first.
   rsp_payload_type expected_digits[$];

   int gap_pct        = 0;  // chance in percent that the driver idles a cycle
   int raised_count   = 0;  // requests the driver has put on the port
   int accepted_count = 0;  // requests the converter has taken
   int mismatch_count = 0;

   unsigned_to_base_digits_unit #(
      .VALUE_BITS(DUT_VALUE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always #5 clock = ~clock;

   // Expand one request into its digits, most significant first, and queue them.
   function automatic void queue_radix_digits(input req_payload_type request);
      logic [63:0]     remaining;
      logic [6:0]      base;
      logic [5:0]      reversed[MAX_DIGITS];
      logic [6:0]      digit_value;
      rsp_payload_type digit;
      int              count;
      remaining = request.value & VALUE_MASK;
      base      = {1'b0, request.radix};
      // Clamp the radix into the legal band before dividing.
      if (base < {1'b0, RADIX_MIN}) begin
         base = {1'b0, RADIX_MIN};
      end
      if (base > {1'b0, RADIX_MAX}) begin
         base = {1'b0, RADIX_MAX};
      end
      count = 0;
      // Peel digits off the bottom; zero still yields one digit.
      do begin
         reversed[count] = 6'(remaining % 64'(base));
         remaining       = remaining / 64'(base);
         count++;
      end while (remaining != 64'd0 && count < MAX_DIGITS);
      for (int k = 0; k < count; k++) begin
         digit_value      = {1'b0, reversed[count-1-k]};
         digit.digit_char = (digit_value < DECIMAL_DIGITS)
                            ? CHAR_ZERO + digit_value
                            : CHAR_UPPER_A + (digit_value - DECIMAL_DIGITS);
         digit.is_last    = (k == count - 1);
         expected_digits.push_back(digit);
      end
   endfunction

   // Driver: change inputs on the falling edge only.
   // Hold a raised request until the converter takes it, otherwise roll for an idle cycle.
   always @(negedge clock) begin
      if (raised_count != accepted_count) begin
         // hold start and payload steady
      end else if (pending_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
         start        <= 1'b1;
         req_payload  <= pending_requests[0];
         raised_count <= raised_count + 1;
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: sample on the rising edge. Check the digit first, then log a taken request,
   // so digits predicted at this edge never meet a result from the same edge.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_strobe) begin
         if (expected_digits.size() == 0) begin
            $error("unexpected digit: digit_char=%0d is_last=%0b",
                   rsp_payload.digit_char, rsp_payload.is_last);
            mismatch_count = mismatch_count + 1;
         end else begin
            want = expected_digits.pop_front();
            if (rsp_payload.digit_char !== want.digit_char) begin
               $error("digit_char: expected %0d, actual %0d",
                      want.digit_char, rsp_payload.digit_char);
               mismatch_count = mismatch_count + 1;
            end
            if (rsp_payload.is_last !== want.is_last) begin
               $error("is_last: expected %0b, actual %0b", want.is_last, rsp_payload.is_last);
               mismatch_count = mismatch_count + 1;
            end
         end
      end
      if (!reset && start && !busy) begin
         queue_radix_digits(pending_requests.pop_front());
         accepted_count <= accepted_count + 1;
      end
   end

   // Stimulus: reset, directed corners, then three random phases with different sender gaps.
   initial begin
      req_payload_type item;
      logic [63:0]     power;
      logic [6:0]      eff_radix;
      int              steps;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 18 : (phase == 1) ? 50 : 0;

         if (phase == 0) begin
            // Zero in several bases gives a lone '0'.
            pending_requests.push_back('{value: 64'd0, radix: 6'd10});
            pending_requests.push_back('{value: 64'd0, radix: 6'd2});
            pending_requests.push_back('{value: 64'd0, radix: 6'd36});
            // Full-scale values: 64 binary digits is the longest string.
            pending_requests.push_back('{value: {64{1'b1}}, radix: 6'd2});
            pending_requests.push_back('{value: {64{1'b1}}, radix: 6'd10});
            pending_requests.push_back('{value: {64{1'b1}}, radix: 6'd36});
            pending_requests.push_back('{value: 64'h8000_0000_0000_0000, radix: 6'd2});
            pending_requests.push_back('{value: 64'h8000_0000_0000_0000, radix: 6'd16});
            pending_requests.push_back('{value: 64'd1, radix: 6'd2});
            // Radix too small is raised to binary.
            pending_requests.push_back('{value: 64'd5, radix: 6'd0});
            pending_requests.push_back('{value: 64'd5, radix: 6'd1});
            // Radix too large is lowered to 36.
            pending_requests.push_back('{value: 64'd35, radix: 6'd37});
            pending_requests.push_back('{value: 64'd36, radix: 6'd63});
            pending_requests.push_back('{value: {64{1'b1}}, radix: 6'd63});
            // Digit coding around the '9'/'A' and 'Z' boundaries.
            pending_requests.push_back('{value: 64'd9, radix: 6'd10});
            pending_requests.push_back('{value: 64'd10, radix: 6'd10});
            pending_requests.push_back('{value: 64'd10, radix: 6'd16});
            pending_requests.push_back('{value: 64'd35, radix: 6'd36});
            pending_requests.push_back('{value: 64'd36, radix: 6'd36});
            pending_requests.push_back('{value: 64'h0123_4567_89AB_CDEF, radix: 6'd16});
            pending_requests.push_back('{value: 64'd1234567890, radix: 6'd10});
            pending_requests.push_back('{value: 64'h5555_5555_5555_5555, radix: 6'd3});
         end

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Mostly legal radices, some from the whole 6-bit range to hit the clamps.
            if ($urandom_range(99) < 80) begin
               item.radix = 6'($urandom_range(36, 2));
            end else begin
               item.radix = 6'($urandom_range(63, 0));
            end
            case ($urandom_range(4, 0))
               0: item.value = {$urandom, $urandom};
               1: item.value = {$urandom, $urandom} >> $urandom_range(63, 0);
               2: item.value = 64'($urandom_range(99, 0));
               3: begin
                  // Land on or just below a power of the radix to flip the digit count.
                  eff_radix = {1'b0, item.radix};
                  if (eff_radix < {1'b0, RADIX_MIN}) begin
                     eff_radix = {1'b0, RADIX_MIN};
                  end
                  if (eff_radix > {1'b0, RADIX_MAX}) begin
                     eff_radix = {1'b0, RADIX_MAX};
                  end
                  power = 64'd1;
                  steps = $urandom_range(64, 1);
                  repeat (steps) begin
                     if (power <= {64{1'b1}} / 64'(eff_radix)) begin
                        power = power * 64'(eff_radix);
                     end
                  end
                  item.value = $urandom_range(1, 0) ? power : power - 64'd1;
               end
               default: item.value = {1'b1, 63'd0} | ({$urandom, $urandom} >> 1);
            endcase
            pending_requests.push_back(item);
         end

         // Advance to the next phase only once every request has been taken.
         while (pending_requests.size() != 0) @(posedge clock);
      end

      // Drain: wait for every owed digit, then watch a while for stray ones.
      while (expected_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
